[hdl/fca_pkg.sv]
package fca_pkg;

   localparam int unsigned NUM_PLANES = 6;
   localparam int unsigned COEF_W     = 32;
   localparam int unsigned ACC_W      = 67;
   localparam int unsigned DVD_W      = 48;
   localparam int unsigned REQ_DATA_W = 232;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned OP_W       = 2;

   typedef enum logic [1:0] {
      OP_WR_MODELVIEW  = 2'd0,
      OP_WR_PROJECTION = 2'd1,
      OP_EXTRACT       = 2'd2,
      OP_TEST_BOX      = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP_MAC,
      ST_CLIP_WR,
      ST_PLANE,
      ST_SQ_MAC,
      ST_SQRT,
      ST_MAG,
      ST_DIV_LD,
      ST_DIV,
      ST_DIV_WR,
      ST_PLANE_WR,
      ST_BOX_MAC,
      ST_BOX_CHK,
      ST_RESP
   } state_type;

   function automatic logic signed [COEF_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi_lim;
      logic signed [ACC_W-1:0] lo_lim;
      hi_lim = ACC_W'(signed'(33'sh0_7FFF_FFFF));
      lo_lim = -hi_lim - ACC_W'(1);
      if (v > hi_lim) begin
         sat32 = {1'b0, {(COEF_W-1){1'b1}}};
      end else if (v < lo_lim) begin
         sat32 = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
         sat32 = v[COEF_W-1:0];
      end
   endfunction

endpackage

[hdl/frustum_aabb_cull_unit.sv]
// Frustum culling unit, signed Q16.16. One item per transfer on req_; only box tests
// produce a transfer on rsp_. Plane extraction runs the clip product on one shared
// 32x32 multiplier, element by element over 16 elements, then per plane forms it,
// with normalization on sums the squares, takes the integer square root and runs a
// bit-serial division per coefficient (skipped when the root is zero), and stores it.
// A box test uses the same multiplier, corner by corner per plane, moves on at a plane's
// first passing corner and posts a response once every plane passes or a plane fails
// on all of its corners. req_tready is high only while the unit is idle.
module frustum_aabb_cull_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic                               csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // element_index, element_value, box_min_x/y/z, box_max_x/y/z, zero pad
   input  logic [fca_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op
   input  logic [fca_pkg::OP_W-1:0]           req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // visible, zero pad
   output logic [fca_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int unsigned CW = fca_pkg::COEF_W;
   localparam int unsigned AW = fca_pkg::ACC_W;
   localparam int unsigned DW = fca_pkg::DVD_W;

   fca_pkg::state_type state_ff, state_in;

   logic signed [CW-1:0] mv_ff   [16];
   logic signed [CW-1:0] mv_in   [16];
   logic signed [CW-1:0] pj_ff   [16];
   logic signed [CW-1:0] pj_in   [16];
   logic signed [CW-1:0] clip_ff [16];
   logic signed [CW-1:0] clip_in [16];
   logic signed [CW-1:0] pl_ff   [6][4];
   logic signed [CW-1:0] pl_in   [6][4];
   logic signed [CW-1:0] cf_ff   [4];
   logic signed [CW-1:0] cf_in   [4];
   logic signed [CW-1:0] bmin_ff [3];
   logic signed [CW-1:0] bmin_in [3];
   logic signed [CW-1:0] bmax_ff [3];
   logic signed [CW-1:0] bmax_in [3];

   logic                 norm_ff, norm_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [3:0]           e_ff, e_in;
   logic [2:0]           i_ff, i_in;
   logic [1:0]           j_ff, j_in;
   logic [2:0]           n_ff, n_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [63:0]   prod_ff, prod_in;
   logic [63:0]          s_ff, s_in;
   logic [63:0]          res_ff, res_in;
   logic [63:0]          bit_ff, bit_in;
   logic [CW-1:0]        mag_ff, mag_in;
   logic [DW-1:0]        dvd_ff, dvd_in;
   logic [33:0]          rem_ff, rem_in;
   logic [DW-1:0]        q_ff, q_in;
   logic                 neg_ff, neg_in;
   logic                 vis_ff, vis_in;
   logic                 rv_ff, rv_in;
   logic                 rd_ff, rd_in;

   logic signed [CW-1:0] mul_a, mul_b;
   logic                 req_fire;
   logic [1:0]           k;
   logic [1:0]           col;
   logic                 sub;
   logic signed [32:0]   w33, o33;
   logic [63:0]          rb;
   logic [33:0]          shr;
   logic signed [DW:0]   qs;
   logic [CW-1:0]        absv;

   assign req_tready = (state_ff == fca_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {{(fca_pkg::RSP_DATA_W-1){1'b0}}, rd_ff};
   assign k          = cnt_ff[1:0];
   assign col        = i_ff[2:1];
   assign sub        = (i_ff == 3'd0) || (i_ff == 3'd3) || (i_ff == 3'd4);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         fca_pkg::ST_CLIP_MAC: begin
            mul_a = mv_ff[{e_ff[3:2], k}];
            mul_b = pj_ff[{k, e_ff[1:0]}];
         end
         fca_pkg::ST_SQ_MAC: begin
            mul_a = cf_ff[k];
            mul_b = cf_ff[k];
         end
         fca_pkg::ST_BOX_MAC: begin
            if (k != 2'd3) begin
               mul_a = pl_ff[i_ff][k];
               mul_b = n_ff[k] ? bmax_ff[k] : bmin_ff[k];
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      mv_in    = mv_ff;
      pj_in    = pj_ff;
      clip_in  = clip_ff;
      pl_in    = pl_ff;
      cf_in    = cf_ff;
      bmin_in  = bmin_ff;
      bmax_in  = bmax_ff;
      norm_in  = csr_we ? csr_wdata : norm_ff;
      cnt_in   = cnt_ff;
      e_in     = e_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      n_in     = n_ff;
      acc_in   = acc_ff;
      s_in     = s_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      mag_in   = mag_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      vis_in   = vis_ff;
      rv_in    = (rv_ff && rsp_tready) ? 1'b0 : rv_ff;
      rd_in    = rd_ff;
      w33      = '0;
      o33      = '0;
      rb       = '0;
      shr      = '0;
      qs       = '0;
      absv     = '0;
      case (state_ff)
         fca_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (fca_pkg::op_type'(req_tuser))
                  fca_pkg::OP_WR_MODELVIEW: mv_in[req_tdata[3:0]] = req_tdata[35:4];
                  fca_pkg::OP_WR_PROJECTION: pj_in[req_tdata[3:0]] = req_tdata[35:4];
                  fca_pkg::OP_EXTRACT: begin
                     e_in     = '0;
                     cnt_in   = '0;
                     acc_in   = '0;
                     state_in = fca_pkg::ST_CLIP_MAC;
                  end
                  fca_pkg::OP_TEST_BOX: begin
                     bmin_in[0] = req_tdata[67:36];
                     bmin_in[1] = req_tdata[99:68];
                     bmin_in[2] = req_tdata[131:100];
                     bmax_in[0] = req_tdata[163:132];
                     bmax_in[1] = req_tdata[195:164];
                     bmax_in[2] = req_tdata[227:196];
                     i_in       = '0;
                     n_in       = '0;
                     cnt_in     = '0;
                     acc_in     = AW'(pl_ff[0][3]) <<< 16;
                     state_in   = fca_pkg::ST_BOX_MAC;
                  end
                  default: state_in = fca_pkg::ST_IDLE;
               endcase
            end
         end
         fca_pkg::ST_CLIP_MAC: begin
            if (cnt_ff != 6'd0) acc_in = acc_ff + AW'(prod_ff);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd4) state_in = fca_pkg::ST_CLIP_WR;
         end
         fca_pkg::ST_CLIP_WR: begin
            clip_in[e_ff] = fca_pkg::sat32(acc_ff >>> 16);
            acc_in        = '0;
            cnt_in        = '0;
            e_in          = e_ff + 4'd1;
            if (e_ff == 4'd15) begin
               i_in     = '0;
               state_in = fca_pkg::ST_PLANE;
            end else begin
               state_in = fca_pkg::ST_CLIP_MAC;
            end
         end
         fca_pkg::ST_PLANE: begin
            for (int jj = 0; jj < 4; jj++) begin
               w33 = 33'(clip_ff[jj*4+3]);
               o33 = 33'(clip_ff[jj*4+int'(col)]);
               cf_in[jj] = fca_pkg::sat32(AW'(sub ? w33 - o33 : w33 + o33));
            end
            cnt_in   = '0;
            acc_in   = '0;
            state_in = norm_ff ? fca_pkg::ST_SQ_MAC : fca_pkg::ST_PLANE_WR;
         end
         fca_pkg::ST_SQ_MAC: begin
            if (cnt_ff != 6'd0) acc_in = acc_ff + AW'(prod_ff);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               s_in     = acc_in[63:0];
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = fca_pkg::ST_SQRT;
            end
         end
         fca_pkg::ST_SQRT: begin
            rb = res_ff + bit_ff;
            if (s_ff >= rb) begin
               s_in   = s_ff - rb;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) state_in = fca_pkg::ST_MAG;
         end
         fca_pkg::ST_MAG: begin
            mag_in   = res_ff[CW-1:0];
            j_in     = '0;
            state_in = (res_ff == 64'd0) ? fca_pkg::ST_PLANE_WR : fca_pkg::ST_DIV_LD;
         end
         fca_pkg::ST_DIV_LD: begin
            neg_in   = cf_ff[j_ff][CW-1];
            absv     = cf_ff[j_ff][CW-1] ? CW'(-cf_ff[j_ff]) : CW'(cf_ff[j_ff]);
            dvd_in   = {absv, 16'd0};
            rem_in   = '0;
            q_in     = '0;
            cnt_in   = '0;
            state_in = fca_pkg::ST_DIV;
         end
         fca_pkg::ST_DIV: begin
            shr = {rem_ff[32:0], dvd_ff[DW-1]};
            if (shr >= {2'b00, mag_ff}) begin
               rem_in = shr - {2'b00, mag_ff};
               q_in   = {q_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = shr;
               q_in   = {q_ff[DW-2:0], 1'b0};
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DW-1)) state_in = fca_pkg::ST_DIV_WR;
         end
         fca_pkg::ST_DIV_WR: begin
            qs = neg_ff ? -signed'({1'b0, q_ff}) : signed'({1'b0, q_ff});
            cf_in[j_ff] = fca_pkg::sat32(AW'(qs));
            j_in = j_ff + 2'd1;
            state_in = (j_ff == 2'd3) ? fca_pkg::ST_PLANE_WR : fca_pkg::ST_DIV_LD;
         end
         fca_pkg::ST_PLANE_WR: begin
            for (int jj = 0; jj < 4; jj++) pl_in[i_ff][jj] = cf_ff[jj];
            i_in = i_ff + 3'd1;
            state_in = (i_ff == 3'(fca_pkg::NUM_PLANES-1)) ? fca_pkg::ST_IDLE
                                                         : fca_pkg::ST_PLANE;
         end
         fca_pkg::ST_BOX_MAC: begin
            if (cnt_ff != 6'd0) acc_in = acc_ff + AW'(prod_ff);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) state_in = fca_pkg::ST_BOX_CHK;
         end
         fca_pkg::ST_BOX_CHK: begin
            cnt_in = '0;
            if (acc_ff > 0) begin
               n_in = '0;
               if (i_ff == 3'(fca_pkg::NUM_PLANES-1)) begin
                  vis_in   = 1'b1;
                  state_in = fca_pkg::ST_RESP;
               end else begin
                  i_in     = i_ff + 3'd1;
                  acc_in   = AW'(pl_ff[i_ff + 3'd1][3]) <<< 16;
                  state_in = fca_pkg::ST_BOX_MAC;
               end
            end else if (n_ff == 3'd7) begin
               vis_in   = 1'b0;
               state_in = fca_pkg::ST_RESP;
            end else begin
               n_in     = n_ff + 3'd1;
               acc_in   = AW'(pl_ff[i_ff][3]) <<< 16;
               state_in = fca_pkg::ST_BOX_MAC;
            end
         end
         fca_pkg::ST_RESP: begin
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               rd_in    = vis_ff;
               state_in = fca_pkg::ST_IDLE;
            end
         end
         default: state_in = fca_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fca_pkg::ST_IDLE;
         norm_ff  <= 1'b1;
         rv_ff    <= 1'b0;
         for (int a = 0; a < 16; a++) begin
            mv_ff[a] <= '0;
            pj_ff[a] <= '0;
         end
         for (int a = 0; a < 6; a++) begin
            for (int b = 0; b < 4; b++) pl_ff[a][b] <= '0;
         end
      end else begin
         state_ff <= state_in;
         norm_ff  <= norm_in;
         rv_ff    <= rv_in;
         mv_ff    <= mv_in;
         pj_ff    <= pj_in;
         pl_ff    <= pl_in;
      end
   end

   always_ff @(posedge clock) begin
      clip_ff <= clip_in;
      cf_ff   <= cf_in;
      bmin_ff <= bmin_in;
      bmax_ff <= bmax_in;
      cnt_ff  <= cnt_in;
      e_ff    <= e_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      s_ff    <= s_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      mag_ff  <= mag_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      vis_ff  <= vis_in;
      rd_ff   <= rd_in;
   end

endmodule

[hdl/fca_checker.sv]
module fca_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [fca_pkg::OP_W-1:0]       req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fca_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer dropped or changed while stalled");

   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_busy_on_box: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == fca_pkg::OP_TEST_BOX |=> !req_tready)
      else $error("ready during box test");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response right after request transfer");

endmodule

bind frustum_aabb_cull_unit fca_checker u_fca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
